// ----- design/slmp_frame_header_parser_top_macros.svh -----
// assertion macros shared by the frame header parser modules
// no dependencies; compiled out when SYNTH is defined
`ifndef SLMP_FRAME_HEADER_PARSER_TOP_MACROS_SVH
`define SLMP_FRAME_HEADER_PARSER_TOP_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define SLMP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("slmp frame header parser assertion failed");
// condition must never be seen outside reset
`define SLMP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("slmp frame header parser assertion failed");
`else
`define SLMP_ASSERT(lbl, clk, rstn, prop)
`define SLMP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- design/slmp_fhp_pkg.sv -----
// types, constants and helper functions of the frame header parser
// no dependencies
`default_nettype none

package slmp_fhp_pkg;

  // subheader words, big endian on the wire
  localparam logic [15:0] SUB_3E_REQ = 16'h5000;
  localparam logic [15:0] SUB_3E_RES = 16'hD000;
  localparam logic [15:0] SUB_4E_REQ = 16'h5400;
  localparam logic [15:0] SUB_4E_RES = 16'hD400;

  // frame format bits: bit0 response, bit1 4e frame
  localparam logic [1:0] FMT_3E_REQ = 2'd0;
  localparam logic [1:0] FMT_3E_RES = 2'd1;
  localparam logic [1:0] FMT_4E_REQ = 2'd2;
  localparam logic [1:0] FMT_4E_RES = 2'd3;

  localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

  // header bytes through the data length field, and the serial offset
  localparam logic [16:0] HDR_3E    = 17'd9;
  localparam logic [16:0] HDR_4E    = 17'd11;
  localparam logic [15:0] BASE_3E   = 16'd2;
  localparam logic [15:0] BASE_4E   = 16'd4;
  localparam logic [15:0] FLOOR_REQ = 16'd6;
  localparam logic [15:0] FLOOR_RES = 16'd2;

  localparam int QUEUE_DEPTH = 2;

  localparam int NUM_PAIRS = 23;
  localparam logic [31:0] KNOWN_PAIRS [NUM_PAIRS] = '{
    32'h04010000, 32'h04010001, 32'h04010002, 32'h04010003,
    32'h14010000, 32'h14010001, 32'h14010002, 32'h14010003,
    32'h04030000, 32'h04030002,
    32'h14020000, 32'h14020001, 32'h14020002, 32'h14020003,
    32'h10010000, 32'h10020000, 32'h10030000, 32'h10050000, 32'h10060000,
    32'h01010000, 32'h16300000, 32'h16310000, 32'h06190000
  };

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_SUB = 3'd1,
    ST_TRUNC   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_SIZE    = 3'd4
  } status_e;

  // captured header fields of one frame
  typedef struct packed {
    logic [1:0]  fmt;
    logic [15:0] serial;
    logic [7:0]  net;
    logic [7:0]  pc;
    logic [15:0] io;
    logic [7:0]  stn;
    logic [15:0] len;
    logic [15:0] tmr;
    logic [15:0] cmd;
    logic [15:0] scmd;
  } frm_t;

  // classified frame handed from front to back
  typedef struct packed {
    status_e status;
    frm_t    frm;
  } rec_t;

  function automatic logic sub_known(input logic [15:0] w);
    return (w == SUB_3E_REQ) || (w == SUB_3E_RES) ||
           (w == SUB_4E_REQ) || (w == SUB_4E_RES);
  endfunction

  // format bits of a subheader, zero when unknown
  function automatic logic [1:0] sub_format(input logic [15:0] w);
    logic [1:0] f;
    f = FMT_3E_REQ;
    if (w == SUB_3E_RES) f = FMT_3E_RES;
    if (w == SUB_4E_REQ) f = FMT_4E_REQ;
    if (w == SUB_4E_RES) f = FMT_4E_RES;
    return f;
  endfunction

  function automatic logic pair_known(input logic [15:0] cmd, input logic [15:0] scmd);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_PAIRS; i++) begin
      if (KNOWN_PAIRS[i] == {cmd, scmd}) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- design/slmp_fhp_front.sv -----
// front end: byte capture, frame classification, max length register
// uses slmp_fhp_pkg and the assertion macro header
`default_nettype none
`include "slmp_frame_header_parser_top_macros.svh"

module slmp_fhp_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               in_last_i,
  input  wire logic               full_i,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i,
  output logic                    push_o,
  output slmp_fhp_pkg::rec_t      rec_o
);
  import slmp_fhp_pkg::*;

  logic        acc;
  logic [15:0] max_len_q;
  logic [15:0] pos_q, pos_d;
  logic [15:0] sub_q, sub_d;
  frm_t        frm_q, cap;
  logic [15:0] base, rel;
  logic [16:0] count, hdr, total;
  logic [15:0] floor_len;
  status_e     status;

  assign acc = in_valid_i && !full_i;

  // capture the current byte into the header fields
  always_comb begin
    cap   = frm_q;
    sub_d = sub_q;
    base  = frm_q.fmt[1] ? BASE_4E : BASE_3E;
    rel   = pos_q - base;
    if (pos_q == 16'd0) begin
      sub_d = {in_byte_i, 8'h00};
    end else if (pos_q == 16'd1) begin
      sub_d   = {sub_q[15:8], in_byte_i};
      cap.fmt = sub_format(sub_d);
    end else if (sub_known(sub_q)) begin
      if (pos_q < base) begin
        if (pos_q == 16'd2) cap.serial[7:0] = in_byte_i;
        else cap.serial[15:8] = in_byte_i;
      end else begin
        unique case (rel)
          16'd0:  cap.net      = in_byte_i;
          16'd1:  cap.pc       = in_byte_i;
          16'd2:  cap.io[7:0]  = in_byte_i;
          16'd3:  cap.io[15:8] = in_byte_i;
          16'd4:  cap.stn      = in_byte_i;
          16'd5:  cap.len[7:0]  = in_byte_i;
          16'd6:  cap.len[15:8] = in_byte_i;
          16'd7:  cap.tmr[7:0]  = in_byte_i;
          16'd8:  cap.tmr[15:8] = in_byte_i;
          16'd9:  if (!frm_q.fmt[0]) cap.cmd[7:0]   = in_byte_i;
          16'd10: if (!frm_q.fmt[0]) cap.cmd[15:8]  = in_byte_i;
          16'd11: if (!frm_q.fmt[0]) cap.scmd[7:0]  = in_byte_i;
          16'd12: if (!frm_q.fmt[0]) cap.scmd[15:8] = in_byte_i;
          default: ;
        endcase
      end
    end
  end

  // classify the frame as it stands after this byte
  always_comb begin
    count     = {1'b0, pos_q} + 17'd1;
    hdr       = cap.fmt[1] ? HDR_4E : HDR_3E;
    total     = hdr + {1'b0, cap.len};
    floor_len = cap.fmt[0] ? FLOOR_RES : FLOOR_REQ;
    if (count < 17'd2) status = ST_TRUNC;
    else if (!sub_known(sub_d)) status = ST_BAD_SUB;
    else if (count < hdr) status = ST_TRUNC;
    else if ((cap.len < floor_len) || (cap.len > max_len_q)) status = ST_RANGE;
    else if (count != total) status = ST_SIZE;
    else status = ST_OK;
  end

  // saturating byte position
  assign pos_d = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;

  assign push_o       = acc && in_last_i;
  assign rec_o.status = status;
  assign rec_o.frm    = cap;

  // frame state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
      pos_q     <= '0;
      sub_q     <= '0;
      frm_q     <= '0;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
      if (acc) begin
        if (in_last_i) begin
          pos_q <= '0;
          sub_q <= '0;
          frm_q <= '0;
        end else begin
          pos_q <= pos_d;
          sub_q <= sub_d;
          frm_q <= cap;
        end
      end
    end
  end

  `SLMP_ASSERT(a_frame_restart, clk_i, rst_ni, push_o |=> ((pos_q == '0) && (frm_q == '0)))

endmodule

`default_nettype wire

// ----- design/slmp_fhp_queue.sv -----
// small fifo of classified frames between front and back end
// uses slmp_fhp_pkg and the assertion macro header
`default_nettype none
`include "slmp_frame_header_parser_top_macros.svh"

module slmp_fhp_queue #(
  parameter int Depth = slmp_fhp_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  slmp_fhp_pkg::rec_t      push_rec_i,
  input  wire logic               pop_i,
  output logic                    full_o,
  output logic                    empty_o,
  output slmp_fhp_pkg::rec_t      pop_rec_o
);
  import slmp_fhp_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  rec_t            slots_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign pop_rec_o = slots_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wptr_q] <= push_rec_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      if (pop_i)  rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  `SLMP_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o && !pop_i)
  `SLMP_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)

endmodule

`default_nettype wire

// ----- design/slmp_fhp_back.sv -----
// back end: command table lookup, field masking, output register
// uses slmp_fhp_pkg and the assertion macro header
`default_nettype none
`include "slmp_frame_header_parser_top_macros.svh"

module slmp_fhp_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  slmp_fhp_pkg::rec_t      rec_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [127:0]            out_data_o,
  output logic [4:0]              out_user_o
);
  import slmp_fhp_pkg::*;

  logic         out_valid_q;
  logic [127:0] data_q, data_d;
  logic [4:0]   user_q, user_d;
  logic         ok, req, known;

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  // mask fields by status and frame kind, pack the result word
  always_comb begin
    ok     = (rec_i.status == ST_OK);
    req    = ok && !rec_i.frm.fmt[0];
    known  = req && pair_known(rec_i.frm.cmd, rec_i.frm.scmd);
    user_d = {ok ? rec_i.frm.fmt : 2'b00, rec_i.status};
    data_d = '0;
    if (ok) begin
      data_d[15:0]   = rec_i.frm.serial;
      data_d[23:16]  = rec_i.frm.net;
      data_d[31:24]  = rec_i.frm.pc;
      data_d[47:32]  = rec_i.frm.io;
      data_d[55:48]  = rec_i.frm.stn;
      data_d[71:56]  = rec_i.frm.len;
      data_d[87:72]  = rec_i.frm.tmr;
    end
    if (req) begin
      data_d[103:88]  = rec_i.frm.cmd;
      data_d[119:104] = rec_i.frm.scmd;
    end
    data_d[120] = known;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;

  `SLMP_ASSERT(a_fail_zeroed, clk_i, rst_ni, (out_valid_q && (user_q[2:0] != ST_OK)) |-> ((data_q == '0) && (user_q[4:3] == 2'b00)))

endmodule

`default_nettype wire

// ----- design/slmp_frame_header_parser_top.sv -----
// byte-serial 3e/4e binary frame header parser, one byte accepted per cycle
// while the queue is not full; a frame's record is queued on its last byte,
// then moves to the back end's output register; up to one status per cycle;
// front and back are decoupled by the QueueDepth-entry queue and that register
// reset: frame state cleared, max data length 8192, queue and output empty
`default_nettype none

module slmp_frame_header_parser_top #(
  parameter int QueueDepth = slmp_fhp_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  wire logic         s_axis_tlast,  // last_byte
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [15:0] frame_serial, [23:16] network_number, [31:24] pc_number,
  // [47:32] module_io_number, [55:48] station_number, [71:56] data_length,
  // [87:72] timer_or_end_code, [103:88] command_code, [119:104] subcommand_code,
  // [120] command_known, [127:121] zero
  output logic [127:0]      m_axis_tdata,
  output logic [4:0]        m_axis_tuser,  // [2:0] status, [4:3] frame_format
  // max data length register
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i
);
  import slmp_fhp_pkg::*;

  logic push, pop, full, empty;
  rec_t push_rec, pop_rec;

  assign s_axis_tready = !full;

  slmp_fhp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .full_i      (full),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  slmp_fhp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .pop_rec_o  (pop_rec)
  );

  slmp_fhp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- bench/slmp_status_checker.sv -----
// status word checker for the frame header parser: watches the byte and status streams
// depends on slmp_fhp_pkg for the status codes, subheader words and header sizes
`timescale 1ns / 1ps

module slmp_status_checker
  import slmp_fhp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         byte_valid_i,
  input  logic         byte_ready_i,
  input  logic [7:0]   byte_i,
  input  logic         byte_last_i,
  input  logic         status_valid_i,
  input  logic         status_ready_i,
  input  logic [127:0] status_data_i,
  input  logic [4:0]   status_user_i,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  output int           mismatch_count_o,
  output int           pending_o
);

  // command/subcommand pairs the parser recognizes, {cmd, subcmd}
  localparam int CmdPairCount = 23;
  localparam logic [31:0] CmdPairTable [CmdPairCount] = '{
    32'h0401_0000, 32'h0401_0001, 32'h0401_0002, 32'h0401_0003,
    32'h1401_0000, 32'h1401_0001, 32'h1401_0002, 32'h1401_0003,
    32'h0403_0000, 32'h0403_0002,
    32'h1402_0000, 32'h1402_0001, 32'h1402_0002, 32'h1402_0003,
    32'h1001_0000, 32'h1002_0000, 32'h1003_0000, 32'h1005_0000, 32'h1006_0000,
    32'h0101_0000, 32'h1630_0000, 32'h1631_0000, 32'h0619_0000
  };

  // one status word as the parser should report it
  typedef struct packed {
    status_e     status;
    logic [1:0]  fmt;
    logic [15:0] serial;
    logic [7:0]  net;
    logic [7:0]  pc;
    logic [15:0] io;
    logic [7:0]  stn;
    logic [15:0] len;
    logic [15:0] tmr;
    logic [15:0] cmd;
    logic [15:0] scmd;
    logic        known;
    logic [6:0]  pad;
  } frame_status_t;

  frame_status_t expected_status_q[$];
  int mismatches = 0;
  int pending = 0;

  // parser state as predicted
  logic [15:0] max_len;
  logic [15:0] pos;
  logic [15:0] sub_w;
  logic [1:0]  fmt_w;
  logic [15:0] serial_w;
  logic [7:0]  net_b;
  logic [7:0]  pc_b;
  logic [15:0] io_w;
  logic [7:0]  stn_b;
  logic [15:0] len_w;
  logic [15:0] tmr_w;
  logic [15:0] cmd_w;
  logic [15:0] scmd_w;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  function automatic logic subheader_valid(input logic [15:0] w);
    case (w)
      SUB_3E_REQ, SUB_3E_RES, SUB_4E_REQ, SUB_4E_RES: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic cmd_pair_listed(input logic [15:0] cmd, input logic [15:0] scmd);
    foreach (CmdPairTable[i]) begin
      if (CmdPairTable[i] == {cmd, scmd}) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic clear_frame();
    pos = '0; sub_w = '0; fmt_w = '0; serial_w = '0; net_b = '0; pc_b = '0;
    io_w = '0; stn_b = '0; len_w = '0; tmr_w = '0; cmd_w = '0; scmd_w = '0;
  endtask

  // capture one byte, and on the last byte of a frame queue its status word
  task automatic take_byte(input logic [7:0] b, input logic is_last);
    logic [15:0]   base;
    logic [15:0]   rel;
    logic          resp;
    logic [16:0]   count;
    logic [16:0]   hdr;
    logic [15:0]   floor_len;
    frame_status_t res;
    if (pos == 16'd0) begin
      sub_w = {b, 8'h00};
    end else if (pos == 16'd1) begin
      sub_w[7:0] = b;
      case (sub_w)
        SUB_3E_RES: fmt_w = FMT_3E_RES;
        SUB_4E_REQ: fmt_w = FMT_4E_REQ;
        SUB_4E_RES: fmt_w = FMT_4E_RES;
        default:    fmt_w = FMT_3E_REQ;
      endcase
    end else if (subheader_valid(sub_w)) begin
      base = fmt_w[1] ? BASE_4E : BASE_3E;
      resp = fmt_w[0];
      if (pos < base) begin
        if (pos == 16'd2) serial_w[7:0] = b;
        else serial_w[15:8] = b;
      end else begin
        rel = pos - base;
        case (rel)
          16'd0:  net_b = b;
          16'd1:  pc_b = b;
          16'd2:  io_w[7:0] = b;
          16'd3:  io_w[15:8] = b;
          16'd4:  stn_b = b;
          16'd5:  len_w[7:0] = b;
          16'd6:  len_w[15:8] = b;
          16'd7:  tmr_w[7:0] = b;
          16'd8:  tmr_w[15:8] = b;
          16'd9:  if (!resp) cmd_w[7:0] = b;
          16'd10: if (!resp) cmd_w[15:8] = b;
          16'd11: if (!resp) scmd_w[7:0] = b;
          16'd12: if (!resp) scmd_w[15:8] = b;
          default: ;
        endcase
      end
    end

    // byte counter saturates at its top value
    count = {1'b0, pos} + 17'd1;
    if (pos != 16'hFFFF) pos = pos + 16'd1;
    if (!is_last) return;

    resp      = fmt_w[0];
    hdr       = fmt_w[1] ? HDR_4E : HDR_3E;
    floor_len = resp ? FLOOR_RES : FLOOR_REQ;
    res       = '0;
    if (count < 17'd2) res.status = ST_TRUNC;
    else if (!subheader_valid(sub_w)) res.status = ST_BAD_SUB;
    else if (count < hdr) res.status = ST_TRUNC;
    else if (len_w < floor_len || len_w > max_len) res.status = ST_RANGE;
    else if (count != hdr + {1'b0, len_w}) res.status = ST_SIZE;
    else res.status = ST_OK;

    // fields are only reported for a good frame
    if (res.status == ST_OK) begin
      res.fmt    = fmt_w;
      res.serial = serial_w;
      res.net    = net_b;
      res.pc     = pc_b;
      res.io     = io_w;
      res.stn    = stn_b;
      res.len    = len_w;
      res.tmr    = tmr_w;
      if (!resp) begin
        res.cmd   = cmd_w;
        res.scmd  = scmd_w;
        res.known = cmd_pair_listed(cmd_w, scmd_w);
      end
    end
    expected_status_q = {expected_status_q, res};
    clear_frame();
  endtask

  task automatic note_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: status word field %s expected %h got %h", $realtime, name, exp_v, act_v);
    end
  endtask

  task automatic compare_status(input frame_status_t exp_s, input frame_status_t act_s);
    note_field("status", exp_s.status, act_s.status);
    note_field("frame_format", exp_s.fmt, act_s.fmt);
    note_field("frame_serial", exp_s.serial, act_s.serial);
    note_field("network_number", exp_s.net, act_s.net);
    note_field("pc_number", exp_s.pc, act_s.pc);
    note_field("module_io_number", exp_s.io, act_s.io);
    note_field("station_number", exp_s.stn, act_s.stn);
    note_field("data_length", exp_s.len, act_s.len);
    note_field("timer_or_end_code", exp_s.tmr, act_s.tmr);
    note_field("command_code", exp_s.cmd, act_s.cmd);
    note_field("subcommand_code", exp_s.scmd, act_s.scmd);
    note_field("command_known", exp_s.known, act_s.known);
    note_field("padding", exp_s.pad, act_s.pad);
  endtask

  // unpack the status word and check it against the oldest prediction
  task automatic take_status();
    frame_status_t act_s;
    act_s.status = status_e'(status_user_i[2:0]);
    act_s.fmt    = status_user_i[4:3];
    act_s.serial = status_data_i[15:0];
    act_s.net    = status_data_i[23:16];
    act_s.pc     = status_data_i[31:24];
    act_s.io     = status_data_i[47:32];
    act_s.stn    = status_data_i[55:48];
    act_s.len    = status_data_i[71:56];
    act_s.tmr    = status_data_i[87:72];
    act_s.cmd    = status_data_i[103:88];
    act_s.scmd   = status_data_i[119:104];
    act_s.known  = status_data_i[120];
    act_s.pad    = status_data_i[127:121];
    if (expected_status_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: status word %h/%h with no frame pending", $realtime,
                 status_user_i, status_data_i);
    end else begin
      compare_status(expected_status_q.pop_front(), act_s);
    end
  endtask

  // sample both streams and the register write at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len = MAX_LEN_RESET;
      clear_frame();
      expected_status_q.delete();
      pending = 0;
    end else begin
      if (status_valid_i && status_ready_i) take_status();
      if (byte_valid_i && byte_ready_i) take_byte(byte_i, byte_last_i);
      if (cfg_we_i) max_len = cfg_wdata_i;
      pending = expected_status_q.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
// top of the frame header parser bench: clock, reset, frame stimulus and verdict
// depends on slmp_fhp_pkg, slmp_frame_header_parser_top and slmp_status_checker
`timescale 1ns / 1ps

module testbench;
  import slmp_fhp_pkg::*;

  localparam int CycleLimit = 1_000_000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [4:0]   m_axis_tuser;
  logic         cfg_we = 1'b0;
  logic [15:0]  cfg_wdata = '0;

  int          mismatch_count;
  int          pending_results;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  bit          no_gaps = 1'b0;
  logic [15:0] cur_max = MAX_LEN_RESET;
  logic [7:0]  frame_q[$];

  slmp_frame_header_parser_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  slmp_status_checker frame_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .byte_valid_i    (s_axis_tvalid),
    .byte_ready_i    (s_axis_tready),
    .byte_i          (s_axis_tdata),
    .byte_last_i     (s_axis_tlast),
    .status_valid_i  (m_axis_tvalid),
    .status_ready_i  (m_axis_tready),
    .status_data_i   (m_axis_tdata),
    .status_user_i   (m_axis_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_results)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL slmp_frame_header_parser_top");
    $finish;
  end

  // status side backpressure: ready stretches, choppy stretches, rare long stalls
  initial begin
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(20, 200)) @(negedge clk);
      end else begin
        repeat ($urandom_range(20, 100)) begin
          if ($urandom_range(0, 99) < 3) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(20, 60)) @(negedge clk);
          end else begin
            m_axis_tready <= ($urandom_range(0, 99) < 70);
            @(negedge clk);
          end
        end
      end
    end
  end

  // idle cycles before a byte word: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] fill_byte(input int fill);
    return (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
  endfunction

  // command pair: table entries, table commands with odd subcommands, or noise
  function automatic logic [31:0] pick_pair();
    logic [31:0] p;
    int          r;
    r = $urandom_range(0, 99);
    p = KNOWN_PAIRS[$urandom_range(0, NUM_PAIRS - 1)];
    if (r < 50) return p;
    if (r < 70) return {p[31:16], 16'($urandom_range(0, 4))};
    return $urandom();
  endfunction

  // declared length, mostly just above the floor
  function automatic logic [15:0] pick_len(input logic [1:0] fmt);
    int floor_len;
    int r;
    floor_len = fmt[0] ? 2 : 6;
    r = $urandom_range(0, 99);
    if (r < 75) return 16'(floor_len + $urandom_range(0, 10));
    if (r < 90) return 16'(floor_len + $urandom_range(0, 60));
    if (cur_max >= floor_len && cur_max <= 120) return cur_max;
    return 16'(floor_len);
  endfunction

  // append one byte to the frame under construction
  task automatic add_byte(input logic [7:0] b);
    frame_q = {frame_q, b};
  endtask

  // drive one byte word and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // header with the given format and declared length, then body_len body bytes;
  // fill < 0 means random field bytes, else non-command field bytes take fill
  task automatic build_frame(input logic [1:0] fmt, input logic [15:0] decl_len,
                             input int body_len, input int fill, input logic [31:0] pair);
    logic [15:0] sub;
    logic [15:0] tmr;
    logic [7:0]  v;
    frame_q.delete();
    case (fmt)
      FMT_3E_RES: sub = SUB_3E_RES;
      FMT_4E_REQ: sub = SUB_4E_REQ;
      FMT_4E_RES: sub = SUB_4E_RES;
      default:    sub = SUB_3E_REQ;
    endcase
    add_byte(sub[15:8]);
    add_byte(sub[7:0]);
    if (fmt[1]) begin
      add_byte(fill_byte(fill));
      add_byte(fill_byte(fill));
    end
    repeat (5) add_byte(fill_byte(fill));
    add_byte(decl_len[7:0]);
    add_byte(decl_len[15:8]);
    tmr = {fill_byte(fill), fill_byte(fill)};
    for (int i = 0; i < body_len; i++) begin
      case (i)
        0: v = tmr[7:0];
        1: v = tmr[15:8];
        2: v = pair[23:16];
        3: v = pair[31:24];
        4: v = pair[7:0];
        5: v = pair[15:8];
        default: v = fill_byte(fill);
      endcase
      if (fmt[0] && i >= 2) v = fill_byte(fill);
      add_byte(v);
    end
  endtask

  // register write once every status word is back and the pipe has drained
  task automatic write_max_len(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_max = v;
  endtask

  // random frames, mostly well formed, until the byte budget is spent
  task automatic run_random(input int budget);
    int          stop;
    int          r;
    int          n;
    int          idx;
    logic [1:0]  fmt;
    logic [15:0] len;
    logic [15:0] decl;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      fmt     = 2'($urandom_range(0, 3));
      len     = pick_len(fmt);
      no_gaps = ($urandom_range(0, 4) == 0);
      r       = $urandom_range(0, 99);
      if (r < 65) begin
        build_frame(fmt, len, len, -1, pick_pair());
      end else if (r < 75) begin
        // body a few bytes longer or shorter than declared
        n = len;
        if ($urandom_range(0, 1)) n = n + $urandom_range(1, 3);
        else n = n - $urandom_range(1, 2);
        build_frame(fmt, len, n, -1, pick_pair());
      end else if (r < 82) begin
        // declared length around the range limits or anywhere
        case ($urandom_range(0, 3))
          0: decl = 16'($urandom_range(0, 65535));
          1: decl = cur_max + 16'd1;
          2: decl = fmt[0] ? 16'd1 : 16'd5;
          default: decl = cur_max;
        endcase
        build_frame(fmt, decl, $urandom_range(0, 12), -1, pick_pair());
      end else if (r < 88) begin
        // cut inside the header
        build_frame(fmt, len, len, -1, pick_pair());
        n = $urandom_range(1, fmt[1] ? 10 : 8);
        while (frame_q.size() > n) void'(frame_q.pop_back());
      end else if (r < 94) begin
        // damaged subheader
        build_frame(fmt, len, len, -1, pick_pair());
        idx = $urandom_range(0, 1);
        if ($urandom_range(0, 1)) frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(0, 7));
        else frame_q[idx] = 8'($urandom_range(0, 255));
      end else begin
        frame_q.delete();
        repeat ($urandom_range(1, 24)) add_byte(8'($urandom_range(0, 255)));
      end
      send_frame();
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single byte, bad subheader, header cut right after the subheader
    frame_q.delete();
    add_byte(8'hFF);
    send_frame();
    frame_q.delete();
    add_byte(8'h50);
    add_byte(8'h01);
    send_frame();
    frame_q.delete();
    add_byte(8'h50);
    add_byte(8'h00);
    send_frame();

    // each format at its floor length with all-zero and all-one fields
    build_frame(FMT_3E_REQ, 16'd6, 6, 0, 32'h0401_0000);
    send_frame();
    build_frame(FMT_3E_RES, 16'd2, 2, 255, 32'h0);
    send_frame();
    build_frame(FMT_4E_REQ, 16'd6, 6, 255, 32'h0619_0000);
    send_frame();
    build_frame(FMT_4E_RES, 16'd2, 2, 0, 32'h0);
    send_frame();

    // length below floor, above maximum, size mismatch, unlisted command pair
    build_frame(FMT_3E_REQ, 16'd5, 5, -1, pick_pair());
    send_frame();
    build_frame(FMT_3E_RES, 16'd1, 1, -1, pick_pair());
    send_frame();
    build_frame(FMT_3E_RES, 16'd0, 0, -1, pick_pair());
    send_frame();
    build_frame(FMT_4E_REQ, MAX_LEN_RESET + 16'd1, 4, -1, pick_pair());
    send_frame();
    build_frame(FMT_3E_REQ, MAX_LEN_RESET, 0, -1, pick_pair());
    send_frame();
    build_frame(FMT_3E_REQ, 16'd7, 8, -1, pick_pair());
    send_frame();
    build_frame(FMT_4E_REQ, 16'd6, 6, -1, 32'h0401_0004);
    send_frame();

    // 4e frame cut inside the data length field
    build_frame(FMT_4E_RES, 16'd2, 2, -1, 32'h0);
    while (frame_q.size() > 10) void'(frame_q.pop_back());
    send_frame();

    run_random(250);

    // widest range
    write_max_len(16'hFFFF);
    run_random(200);

    write_max_len(16'h0000);
    run_random(150);
    write_max_len(16'd6);
    run_random(200);
    write_max_len(16'd2);
    run_random(200);
    write_max_len(16'($urandom_range(3, 40)));
    run_random(200);
    write_max_len(MAX_LEN_RESET);
    run_random(250);

    // drain and settle
    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS slmp_frame_header_parser_top");
    end else begin
      $display("FAIL slmp_frame_header_parser_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/slmp_fhp_pkg.sv
design/slmp_fhp_front.sv
design/slmp_fhp_queue.sv
design/slmp_fhp_back.sv
design/slmp_frame_header_parser_top.sv
bench/slmp_status_checker.sv
bench/testbench.sv
